FILE: src/ehash_pkg.sv
// Shared types and codes for the extendible hash table engine.
`timescale 1ns / 1ps

package ehash_pkg;

    // Request operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // Response status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DIR_RD,
        S_BKT_RD,
        S_BKT_CHK,
        S_DBL,
        S_SPLIT_OLD,
        S_SPLIT_NEW,
        S_REPOINT,
        S_RESP
    } state_t;

endpackage

FILE: src/ehash_if.sv
// Request and response channel interfaces of the extendible hash table.
`timescale 1ns / 1ps

interface ehash_req_if #(
    parameter int KW = 32,
    parameter int VW = 32
);
    logic          valid;
    logic          ready;
    logic [1:0]    operation;
    logic [KW-1:0] key;
    logic [VW-1:0] value;

    modport source (output valid, output operation, output key, output value, input ready);
    modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

interface ehash_rsp_if #(
    parameter int VW = 32
);
    logic          valid;
    logic          ready;
    logic [1:0]    status;
    logic [VW-1:0] value_out;
    logic [2:0]    global_depth;
    logic [6:0]    bucket_count;
    logic [2:0]    bucket_depth;

    modport source (output valid, output status, output value_out, output global_depth,
                    output bucket_count, output bucket_depth, input ready);
    modport sink   (input valid, input status, input value_out, input global_depth,
                    input bucket_count, input bucket_depth, output ready);
endinterface

FILE: src/ehash_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module ehash_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data holds while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/extendible_hash_table.sv
// Extendible hash table engine: top level with sequencer and two RAMs.
`timescale 1ns / 1ps
//
// Usage:
//   req channel (sink): operation, key, value. operation is insert/update,
//   find or remove. A request is taken when valid and ready are both high;
//   ready is high only while the engine is idle.
//   rsp channel (source): status, value_out, global_depth, bucket_count,
//   bucket_depth, one response per request, from an output register.
//   Flow: find, remove and plain insert pass through directory read, bucket
//   read and bucket check to the response. Each split adds row writes, a
//   repoint pass and a new lookup; doubling first adds a copy pass at the old
//   depth. Each pass walks 2^global_depth directory entries through the directory RAM port.
//   The next request is taken only once the previous response has gone to its register.
//   A whole bucket is one RAM row, so its slots are compared in parallel.
//   Reset: table holds one empty bucket, global depth 0. No clearing pass;
//   entry zero of the directory and bucket zero read as reset values until
//   first written.
//   Receiver stall: the response waits in its register; the engine takes
//   the next request and holds its response until the register frees.
//
module extendible_hash_table #(
    parameter int BUCKET_SLOTS     = 4,
    parameter int MAX_GLOBAL_DEPTH = 6,
    parameter int KEY_WIDTH        = 32,
    parameter int VALUE_WIDTH      = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    ehash_req_if.sink   req,
    ehash_rsp_if.source rsp
);

    localparam int DIR_AW   = MAX_GLOBAL_DEPTH;
    localparam int DIR_SIZE = 1 << DIR_AW;
    localparam int GDW      = $clog2(MAX_GLOBAL_DEPTH + 1);
    localparam int FW       = $clog2(BUCKET_SLOTS + 1);
    localparam int SIW      = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
    localparam int KB       = BUCKET_SLOTS * KEY_WIDTH;
    localparam int VB       = BUCKET_SLOTS * VALUE_WIDTH;
    localparam int ROW_W    = GDW + FW + VB + KB;

    ehash_pkg::state_t state_reg, state_next;

    // Control registers
    logic [GDW-1:0]    gd_reg;
    logic [DIR_AW:0]   bu_reg;
    logic              drop_reg;
    logic              dir0_wr_reg;
    logic              bkt0_wr_reg;
    logic [DIR_AW:0]   pass_cnt_reg;
    logic              pass_pend_reg;
    logic              rsp_valid_reg;

    // Payload registers
    logic [1:0]             op_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [DIR_AW-1:0]      b_reg;
    logic [DIR_AW-1:0]      nb_reg;
    logic [GDW-1:0]         row_ld_reg;
    logic [FW-1:0]          row_fill_reg;
    logic [DIR_AW-1:0]      pass_addr_reg;
    logic [DIR_AW-1:0]      dir_raddr_reg;
    logic [DIR_AW-1:0]      bkt_raddr_reg;
    logic [1:0]             res_status_reg;
    logic [VALUE_WIDTH-1:0] res_value_reg;
    logic [1:0]             rsp_status_reg;
    logic [VALUE_WIDTH-1:0] rsp_value_reg;
    logic [2:0]             rsp_gd_reg;
    logic [6:0]             rsp_bu_reg;
    logic [2:0]             rsp_ld_reg;

    // RAM ports
    logic              dir_wr_en, dir_rd_en;
    logic [DIR_AW-1:0] dir_wr_addr, dir_rd_addr, dir_wr_data, dir_rd_data, dir_q;
    logic              bkt_wr_en, bkt_rd_en;
    logic [DIR_AW-1:0] bkt_wr_addr, bkt_rd_addr;
    logic [ROW_W-1:0]  bkt_wr_data, bkt_rd_data;

    ehash_ram #(.WIDTH(DIR_AW), .DEPTH(DIR_SIZE)) u_dir_ram (
        .clk     (clk),
        .wr_en   (dir_wr_en),
        .wr_addr (dir_wr_addr),
        .wr_data (dir_wr_data),
        .rd_en   (dir_rd_en),
        .rd_addr (dir_rd_addr),
        .rd_data (dir_rd_data)
    );

    ehash_ram #(.WIDTH(ROW_W), .DEPTH(DIR_SIZE)) u_bkt_ram (
        .clk     (clk),
        .wr_en   (bkt_wr_en),
        .wr_addr (bkt_wr_addr),
        .wr_data (bkt_wr_data),
        .rd_en   (bkt_rd_en),
        .rd_addr (bkt_rd_addr),
        .rd_data (bkt_rd_data)
    );

    // Directory index of the key: low global-depth bits
    logic [DIR_AW+KEY_WIDTH-1:0] key_wide;
    logic [DIR_AW-1:0]           key_idx;
    assign key_wide = {{DIR_AW{1'b0}}, key_reg};
    assign key_idx  = key_wide[DIR_AW-1:0] & ~({DIR_AW{1'b1}} << gd_reg);

    // Unwritten entry zero / bucket zero read as reset values
    assign dir_q = (dir_raddr_reg == '0 && !dir0_wr_reg) ? '0 : dir_rd_data;

    logic [KEY_WIDTH-1:0]   row_key [BUCKET_SLOTS];
    logic [VALUE_WIDTH-1:0] row_val [BUCKET_SLOTS];
    logic [FW-1:0]          row_fill;
    logic [GDW-1:0]         row_ld;
    logic                   bkt_blank;

    assign bkt_blank = (bkt_raddr_reg == '0) && !bkt0_wr_reg;
    assign row_fill  = bkt_blank ? '0 : bkt_rd_data[KB+VB +: FW];
    assign row_ld    = bkt_blank ? '0 : bkt_rd_data[KB+VB+FW +: GDW];

    always_comb
    begin
        for (int j = 0; j < BUCKET_SLOTS; j++)
        begin
            row_key[j] = bkt_rd_data[j*KEY_WIDTH +: KEY_WIDTH];
            row_val[j] = bkt_rd_data[KB + j*VALUE_WIDTH +: VALUE_WIDTH];
        end
    end

    // Parallel key compare across the bucket
    logic           hit_any;
    logic [SIW-1:0] hit_idx;

    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int j = BUCKET_SLOTS - 1; j >= 0; j--)
        begin
            if (FW'(j) < row_fill && row_key[j] == key_reg)
            begin
                hit_any = 1'b1;
                hit_idx = SIW'(j);
            end
        end
    end

    // Split decision
    logic bucket_full, need_dbl, dir_maxed, no_bucket, split_go;
    assign bucket_full = (row_fill == FW'(BUCKET_SLOTS));
    assign need_dbl    = (row_ld >= gd_reg);
    assign dir_maxed   = (gd_reg >= GDW'(MAX_GLOBAL_DEPTH));
    assign no_bucket   = (bu_reg >= (DIR_AW+1)'(DIR_SIZE));
    assign split_go    = !drop_reg && op_reg == ehash_pkg::OP_INSERT && !hit_any
                         && bucket_full && !(need_dbl && dir_maxed)
                         && !(!need_dbl && no_bucket);

    // Directory pass counter
    logic [DIR_AW:0] span;
    logic            pass_issue, pass_done;
    assign span       = (DIR_AW+1)'(1) << gd_reg;
    assign pass_issue = pass_cnt_reg < span;
    assign pass_done  = !pass_issue && !pass_pend_reg;

    logic out_free;
    assign out_free = !rsp_valid_reg || rsp.ready;

    // Split redistribution: entries with the bit at the old local depth move
    logic [KEY_WIDTH-1:0]   kk [BUCKET_SLOTS];
    logic [VALUE_WIDTH-1:0] kv [BUCKET_SLOTS];
    logic [KEY_WIDTH-1:0]   mk [BUCKET_SLOTS];
    logic [VALUE_WIDTH-1:0] mv [BUCKET_SLOTS];
    logic [FW-1:0]          kc, mc;

    always_comb
    begin
        kk = row_key;
        kv = row_val;
        mk = row_key;
        mv = row_val;
        kc = '0;
        mc = '0;
        for (int j = 0; j < BUCKET_SLOTS; j++)
        begin
            if (FW'(j) < row_fill_reg)
            begin
                if (int'(row_ld_reg) < KEY_WIDTH && row_key[j][row_ld_reg])
                begin
                    mk[mc[SIW-1:0]] = row_key[j];
                    mv[mc[SIW-1:0]] = row_val[j];
                    mc = mc + FW'(1);
                end
                else
                begin
                    kk[kc[SIW-1:0]] = row_key[j];
                    kv[kc[SIW-1:0]] = row_val[j];
                    kc = kc + FW'(1);
                end
            end
        end
    end

    // Bucket row to write back
    logic [KEY_WIDTH-1:0]   wk [BUCKET_SLOTS];
    logic [VALUE_WIDTH-1:0] wv [BUCKET_SLOTS];
    logic [FW-1:0]          wfill, last;
    logic [GDW-1:0]         wld;

    always_comb
    begin
        wk    = row_key;
        wv    = row_val;
        wfill = row_fill;
        wld   = row_ld;
        last  = row_fill - FW'(1);
        unique case (state_reg)
            ehash_pkg::S_SPLIT_OLD:
            begin
                wk    = kk;
                wv    = kv;
                wfill = kc;
                wld   = row_ld_reg + GDW'(1);
            end
            ehash_pkg::S_SPLIT_NEW:
            begin
                wk    = mk;
                wv    = mv;
                wfill = mc;
                wld   = row_ld_reg + GDW'(1);
            end
            default:
            begin
                if (op_reg == ehash_pkg::OP_REMOVE)
                begin
                    wk[hit_idx] = row_key[last[SIW-1:0]];
                    wv[hit_idx] = row_val[last[SIW-1:0]];
                    wfill       = last;
                end
                else if (hit_any)
                begin
                    wv[hit_idx] = value_reg;
                end
                else
                begin
                    wk[row_fill[SIW-1:0]] = key_reg;
                    wv[row_fill[SIW-1:0]] = value_reg;
                    wfill                 = row_fill + FW'(1);
                end
            end
        endcase
        bkt_wr_data[KB+VB+FW +: GDW] = wld;
        bkt_wr_data[KB+VB +: FW]     = wfill;
        for (int j = 0; j < BUCKET_SLOTS; j++)
        begin
            bkt_wr_data[j*KEY_WIDTH +: KEY_WIDTH]          = wk[j];
            bkt_wr_data[KB + j*VALUE_WIDTH +: VALUE_WIDTH] = wv[j];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ehash_pkg::S_IDLE:      if (req.valid) state_next = ehash_pkg::S_DIR_RD;
            ehash_pkg::S_DIR_RD:    state_next = ehash_pkg::S_BKT_RD;
            ehash_pkg::S_BKT_RD:    state_next = ehash_pkg::S_BKT_CHK;
            ehash_pkg::S_BKT_CHK:
            begin
                if (split_go)
                    state_next = need_dbl ? ehash_pkg::S_DBL : ehash_pkg::S_SPLIT_OLD;
                else
                    state_next = ehash_pkg::S_RESP;
            end
            ehash_pkg::S_DBL:
            begin
                if (pass_done)
                    state_next = no_bucket ? ehash_pkg::S_DIR_RD : ehash_pkg::S_SPLIT_OLD;
            end
            ehash_pkg::S_SPLIT_OLD: state_next = ehash_pkg::S_SPLIT_NEW;
            ehash_pkg::S_SPLIT_NEW: state_next = ehash_pkg::S_REPOINT;
            ehash_pkg::S_REPOINT:   if (pass_done) state_next = ehash_pkg::S_DIR_RD;
            ehash_pkg::S_RESP:      if (out_free) state_next = ehash_pkg::S_IDLE;
            default:                state_next = ehash_pkg::S_IDLE;
        endcase
    end

    // Memory controls and handshake outputs
    always_comb
    begin
        req.ready   = (state_reg == ehash_pkg::S_IDLE);
        dir_rd_en   = 1'b0;
        dir_rd_addr = pass_cnt_reg[DIR_AW-1:0];
        dir_wr_en   = 1'b0;
        dir_wr_addr = pass_addr_reg;
        dir_wr_data = dir_q;
        bkt_rd_en   = 1'b0;
        bkt_rd_addr = dir_q;
        bkt_wr_en   = 1'b0;
        bkt_wr_addr = b_reg;
        unique case (state_reg)
            ehash_pkg::S_DIR_RD:
            begin
                dir_rd_en   = 1'b1;
                dir_rd_addr = key_idx;
            end
            ehash_pkg::S_BKT_RD:
            begin
                bkt_rd_en = 1'b1;
            end
            ehash_pkg::S_BKT_CHK:
            begin
                bkt_wr_en = !drop_reg
                            && ((op_reg == ehash_pkg::OP_REMOVE && hit_any)
                                || (op_reg == ehash_pkg::OP_INSERT
                                    && (hit_any || !bucket_full)));
            end
            ehash_pkg::S_DBL:
            begin
                dir_rd_en   = pass_issue;
                dir_wr_en   = pass_pend_reg;
                dir_wr_addr = pass_addr_reg + span[DIR_AW-1:0];
            end
            ehash_pkg::S_SPLIT_OLD:
            begin
                bkt_wr_en = 1'b1;
            end
            ehash_pkg::S_SPLIT_NEW:
            begin
                bkt_wr_en   = 1'b1;
                bkt_wr_addr = bu_reg[DIR_AW-1:0];
            end
            ehash_pkg::S_REPOINT:
            begin
                dir_rd_en   = pass_issue;
                dir_wr_en   = pass_pend_reg && dir_q == b_reg
                              && pass_addr_reg[row_ld_reg];
                dir_wr_data = nb_reg;
            end
            default:
            begin
                dir_rd_en = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ehash_pkg::S_IDLE;
            gd_reg        <= '0;
            bu_reg        <= (DIR_AW+1)'(1);
            drop_reg      <= 1'b0;
            dir0_wr_reg   <= 1'b0;
            bkt0_wr_reg   <= 1'b0;
            pass_cnt_reg  <= '0;
            pass_pend_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (dir_wr_en && dir_wr_addr == '0)
                dir0_wr_reg <= 1'b1;
            if (bkt_wr_en && bkt_wr_addr == '0)
                bkt0_wr_reg <= 1'b1;
            if (state_reg == ehash_pkg::S_IDLE && req.valid)
                drop_reg <= 1'b0;
            if (state_reg == ehash_pkg::S_BKT_CHK || state_reg == ehash_pkg::S_SPLIT_NEW)
            begin
                pass_cnt_reg  <= '0;
                pass_pend_reg <= 1'b0;
            end
            if (state_reg == ehash_pkg::S_DBL || state_reg == ehash_pkg::S_REPOINT)
            begin
                pass_pend_reg <= pass_issue;
                if (pass_issue)
                    pass_cnt_reg <= pass_cnt_reg + (DIR_AW+1)'(1);
            end
            // Directory doubled: grow depth, drop if no bucket is left
            if (state_reg == ehash_pkg::S_DBL && pass_done)
            begin
                gd_reg <= gd_reg + GDW'(1);
                if (no_bucket)
                    drop_reg <= 1'b1;
            end
            if (state_reg == ehash_pkg::S_SPLIT_NEW)
                bu_reg <= bu_reg + (DIR_AW+1)'(1);
            if (state_reg == ehash_pkg::S_RESP && out_free)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ehash_pkg::S_IDLE && req.valid)
        begin
            op_reg    <= req.operation;
            key_reg   <= req.key;
            value_reg <= req.value;
        end
        if (dir_rd_en)
            dir_raddr_reg <= dir_rd_addr;
        if (bkt_rd_en)
            bkt_raddr_reg <= bkt_rd_addr;
        if (state_reg == ehash_pkg::S_BKT_RD)
            b_reg <= dir_q;
        if (state_reg == ehash_pkg::S_DBL || state_reg == ehash_pkg::S_REPOINT)
            pass_addr_reg <= pass_cnt_reg[DIR_AW-1:0];
        if (state_reg == ehash_pkg::S_SPLIT_NEW)
            nb_reg <= bu_reg[DIR_AW-1:0];
        // Result of the final bucket check
        if (state_reg == ehash_pkg::S_BKT_CHK)
        begin
            row_ld_reg    <= row_ld;
            row_fill_reg  <= row_fill;
            res_value_reg <= '0;
            if (drop_reg)
                res_status_reg <= ehash_pkg::ST_FULL;
            else if (op_reg == ehash_pkg::OP_INSERT)
                res_status_reg <= (hit_any || !bucket_full) ? ehash_pkg::ST_OK
                                                            : ehash_pkg::ST_FULL;
            else if (op_reg == ehash_pkg::OP_FIND || op_reg == ehash_pkg::OP_REMOVE)
            begin
                res_status_reg <= hit_any ? ehash_pkg::ST_OK : ehash_pkg::ST_NOTFOUND;
                if (hit_any && op_reg == ehash_pkg::OP_FIND)
                    res_value_reg <= row_val[hit_idx];
            end
            else
                res_status_reg <= ehash_pkg::ST_NOTFOUND;
        end
        if (state_reg == ehash_pkg::S_RESP && out_free)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_value_reg  <= res_value_reg;
            rsp_gd_reg     <= 3'(gd_reg);
            rsp_bu_reg     <= 7'(bu_reg);
            rsp_ld_reg     <= 3'(row_ld_reg);
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.value_out    = rsp_value_reg;
    assign rsp.global_depth = rsp_gd_reg;
    assign rsp.bucket_count = rsp_bu_reg;
    assign rsp.bucket_depth = rsp_ld_reg;

endmodule
